### rtl/core/ccr_pkg.sv
// Package with the shared constants, codes and control types of the random-replacement cache.
`default_nettype none
package ccr_pkg;
  localparam int CACHE_LINES = 64;
  localparam int LINE_W      = 6;
  localparam int BLOCK_WORDS = 4;
  localparam int BW_W        = 2;
  localparam int WAYS_MAX    = 8;
  localparam int WAY_W       = 3;
  localparam int MEM_WORDS   = 65536;
  localparam int MEM_AW      = 16;
  localparam int TAG_W       = 14;
  localparam int CNT_W       = 7;
  localparam int MODE_W      = 4;
  localparam int ADDR_W      = 17;
  localparam int DATA_W      = 32;
  localparam int REG_W       = 4;
  localparam int KIND_W      = 2;
  localparam int IN_W        = 56;
  localparam int OUT_W       = 104;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRELOAD = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DIRECT = 4'd0;
  localparam logic [MODE_W-1:0] MODE_FULL   = 4'd1;

  localparam logic [15:0] LFSR_MASK = 16'hB400;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_LOOK, S_CMP, S_PICK, S_FILL, S_ACC, S_FIN
  } state_t;

  typedef struct packed {
    logic latch;
    logic dec;
    logic look;
    logic cmp;
    logic pick;
    logic fill;
    logic acc;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic mem_op;
    logic hit_now;
    logic last;
    logic fill_done;
    logic clearing;
  } status_t;
endpackage
`default_nettype wire

### rtl/core/configurable_cache_random_replace.sv
// Top level of the write-through cache with random replacement.
// Input words carry a load, a store or a backing-memory preload; each gives
// exactly one result word. The cache mode is written through cfg_we and
// cfg_wdata (0 direct mapped, 1 fully associative, 2 to 8 ways per set); the
// user must write it only while the block is idle, which the block itself
// does not enforce. One word is handled at a time. A bad address, a preload
// or an unused kind goes from decode straight to the result state. A lookup
// walks the candidates in order through the single tag memory port, reading
// and comparing one tag per candidate; a hit goes on to the word access, a
// miss picks a victim and fills the four-word block first. The next input
// word can be taken in the cycle after the result has been delivered.
// Reset clears the counters and the mode, loads the victim LFSR with all
// ones and starts a clearing pass over the tag memories, which hold the
// valid flags; in_tready stays low until it has finished.
// The result is held in an output register until out_tready is high.
`default_nettype none
module configurable_cache_random_replace (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  // kind [1:0], address [18:2], store_data [50:19], dest_reg [54:51]
  input  wire [ccr_pkg::IN_W-1:0]    in_tdata,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  // read_data [31:0], dest_reg_out [35:32], was_hit [36], bad_address [37],
  // hits_so_far [69:38], misses_so_far [101:70]
  output logic [ccr_pkg::OUT_W-1:0]  out_tdata,
  input  wire                        cfg_we,
  input  wire [ccr_pkg::MODE_W-1:0]  cfg_wdata
);
  import ccr_pkg::*;

  cmd_t    cmd;
  status_t sts;

  ccr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ccr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_tdata),
    .out_word  (out_tdata)
  );
endmodule
`default_nettype wire

### rtl/core/ccr_ctrl.sv
// Controller state machine that sequences lookup, fill and access of one word.
`default_nettype none
module ccr_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire            out_tready,
  input  ccr_pkg::status_t sts,
  output ccr_pkg::cmd_t  cmd
);
  import ccr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_tvalid && !out_valid_r && !sts.clearing) state_nxt = S_DEC;
      S_DEC:  state_nxt = sts.mem_op ? S_LOOK : S_FIN;
      S_LOOK: state_nxt = S_CMP;
      S_CMP: begin
        if (sts.hit_now) state_nxt = S_ACC;
        else if (sts.last) state_nxt = S_PICK;
        else state_nxt = S_LOOK;
      end
      S_PICK: state_nxt = S_FILL;
      S_FILL: if (sts.fill_done) state_nxt = S_ACC;
      S_ACC:  state_nxt = S_FIN;
      S_FIN: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = (state_r == S_IDLE) && !out_valid_r && !sts.clearing;
    out_tvalid = out_valid_r;
    case (state_r)
      S_IDLE: cmd.latch = in_tvalid && !out_valid_r && !sts.clearing;
      S_DEC:  cmd.dec   = 1'b1;
      S_LOOK: cmd.look  = 1'b1;
      S_CMP:  cmd.cmp   = 1'b1;
      S_PICK: cmd.pick  = 1'b1;
      S_FILL: cmd.fill  = 1'b1;
      S_ACC:  cmd.acc   = 1'b1;
      S_FIN:  cmd.fin   = 1'b1;
      default: cmd = '0;
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one command active");
  a_fill_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && !sts.fill_done) |=> state_r == S_FILL)
    else $error("fill left early");
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_DEC)
    else $error("accepted word not decoded");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_tvalid)
    else $error("result not presented");
endmodule
`default_nettype wire

### rtl/core/ccr_datapath.sv
// Datapath with backing memory, line and way stores, counters and victim LFSR.
`default_nettype none
module ccr_datapath (
  input  wire                         clk,
  input  wire                         rst_n,
  input  ccr_pkg::cmd_t               cmd,
  output ccr_pkg::status_t            sts,
  input  wire                         cfg_we,
  input  wire [ccr_pkg::MODE_W-1:0]   cfg_wdata,
  input  wire [ccr_pkg::IN_W-1:0]     in_word,
  output logic [ccr_pkg::OUT_W-1:0]   out_word
);
  import ccr_pkg::*;

  // Each tag entry holds its valid flag in the top bit.
  logic [DATA_W-1:0] backing_mem [MEM_WORDS];
  logic [TAG_W:0]    line_tag_mem [CACHE_LINES];
  logic [DATA_W-1:0] line_word_mem [CACHE_LINES*BLOCK_WORDS];
  logic [TAG_W:0]    way_tag_mem [CACHE_LINES*WAYS_MAX];
  logic [DATA_W-1:0] way_word_mem [CACHE_LINES*WAYS_MAX*BLOCK_WORDS];

  logic               clr_busy_r;
  logic [LINE_W+WAY_W-1:0] clr_idx_r;
  logic [MODE_W-1:0]  mode_r;
  logic [KIND_W-1:0]  kind_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [DATA_W-1:0]  data_r;
  logic [REG_W-1:0]   dest_r;
  logic               way_sel_r, dm_r;
  logic [CNT_W-1:0]   n_r, i_r;
  logic               hit_r, empty_r;
  logic [LINE_W-1:0]  empty_slot_r, slot_r, slot_nxt;
  logic [2:0]         k_r;
  logic [15:0]        lfsr_r, lfsr_nxt;
  logic [DATA_W-1:0]  hits_r, misses_r, rd_r;
  logic               hit_out_r, bad_out_r;
  logic [REG_W-1:0]   dest_out_r;
  logic [TAG_W:0]     line_tag_q, way_tag_q, tag_q;
  logic [DATA_W-1:0]  bk_q, line_word_q, way_word_q;

  logic [MEM_AW-1:0]  off;
  logic [TAG_W-1:0]   block;
  logic [BW_W-1:0]    word;
  logic               bad, mem_op, load;
  logic [LINE_W-1:0]  l_idx, l_pick;
  logic [LINE_W+WAY_W-1:0] w_idx, w_pick;
  logic               cand_valid;
  logic [22:0]        prod;
  logic [ADDR_W-1:0]  in_addr;

  assign off    = addr_r[MEM_AW-1:0] - MEM_AW'(1);
  assign block  = off[MEM_AW-1:BW_W];
  assign word   = off[BW_W-1:0];
  assign bad    = (addr_r == '0) || (addr_r > ADDR_W'(MEM_WORDS));
  assign mem_op = !bad && (kind_r == KIND_LOAD || kind_r == KIND_STORE);
  assign load   = kind_r == KIND_LOAD;
  assign in_addr = in_word[KIND_W +: ADDR_W];

  assign l_idx  = dm_r ? block[LINE_W-1:0] : i_r[LINE_W-1:0];
  assign w_idx  = {block[LINE_W-1:0], i_r[WAY_W-1:0]};
  assign l_pick = dm_r ? block[LINE_W-1:0] : slot_r;
  assign w_pick = {block[LINE_W-1:0], slot_r[WAY_W-1:0]};
  assign tag_q  = way_sel_r ? way_tag_q : line_tag_q;
  assign cand_valid = tag_q[TAG_W];

  assign sts.mem_op    = mem_op;
  assign sts.hit_now   = cand_valid && (tag_q[TAG_W-1:0] == block);
  assign sts.last      = (i_r + CNT_W'(1)) == n_r;
  assign sts.fill_done = k_r == 3'd4;
  assign sts.clearing  = clr_busy_r;

  always_comb begin
    lfsr_nxt = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? LFSR_MASK : 16'h0);
    prod     = 23'(lfsr_nxt) * 23'(n_r);
    if (empty_r) slot_nxt = empty_slot_r;
    else if (n_r > CNT_W'(1)) slot_nxt = prod[16 +: LINE_W];
    else slot_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      mode_r     <= MODE_DIRECT;
      hits_r     <= '0;
      misses_r   <= '0;
      lfsr_r     <= 16'hFFFF;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == '1) clr_busy_r <= 1'b0;
      end
      if (cfg_we) mode_r <= cfg_wdata;
      if (cmd.pick) begin
        if (!empty_r && n_r > CNT_W'(1)) lfsr_r <= lfsr_nxt;
      end
      if (cmd.fin && mem_op && load) begin
        if (hit_r) hits_r <= hits_r + DATA_W'(1);
        else misses_r <= misses_r + DATA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_word[KIND_W-1:0];
      addr_r <= in_addr;
      data_r <= in_word[KIND_W+ADDR_W +: DATA_W];
      dest_r <= in_word[KIND_W+ADDR_W+DATA_W +: REG_W];
      hit_r  <= 1'b0;
    end
    if (cmd.dec) begin
      way_sel_r <= mode_r > MODE_FULL;
      dm_r      <= mode_r == MODE_DIRECT;
      if (mode_r == MODE_DIRECT) n_r <= CNT_W'(1);
      else if (mode_r == MODE_FULL) n_r <= CNT_W'(CACHE_LINES);
      else if (mode_r > MODE_W'(WAYS_MAX)) n_r <= CNT_W'(WAYS_MAX);
      else n_r <= CNT_W'(mode_r);
      i_r     <= '0;
      empty_r <= 1'b0;
    end
    if (cmd.cmp) begin
      if (sts.hit_now) begin
        hit_r  <= 1'b1;
        slot_r <= i_r[LINE_W-1:0];
      end else if (!cand_valid && !empty_r) begin
        empty_r      <= 1'b1;
        empty_slot_r <= i_r[LINE_W-1:0];
      end
      i_r <= i_r + CNT_W'(1);
    end
    if (cmd.pick) begin
      slot_r <= slot_nxt;
      k_r    <= '0;
    end
    if (cmd.fill) k_r <= k_r + 3'd1;
    if (cmd.fin) begin
      rd_r       <= (mem_op && load) ? (way_sel_r ? way_word_q : line_word_q) : '0;
      dest_out_r <= dest_r;
      hit_out_r  <= hit_r;
      bad_out_r  <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      line_tag_q <= line_tag_mem[l_idx];
      way_tag_q  <= way_tag_mem[w_idx];
    end
    if (clr_busy_r) begin
      way_tag_mem[clr_idx_r]              <= '0;
      line_tag_mem[clr_idx_r[LINE_W-1:0]] <= '0;
    end else if (cmd.pick) begin
      if (way_sel_r) way_tag_mem[{block[LINE_W-1:0], slot_nxt[WAY_W-1:0]}] <= {1'b1, block};
      else line_tag_mem[dm_r ? block[LINE_W-1:0] : slot_nxt] <= {1'b1, block};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) bk_q <= backing_mem[{block, k_r[BW_W-1:0]}];
    if ((cmd.dec && !bad && kind_r == KIND_PRELOAD) || (cmd.acc && !load))
      backing_mem[off] <= data_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.fill && k_r != 3'd0) begin
      if (way_sel_r) way_word_mem[{w_pick, 2'(k_r - 3'd1)}] <= bk_q;
      else line_word_mem[{l_pick, 2'(k_r - 3'd1)}] <= bk_q;
    end else if (cmd.acc && !load) begin
      if (way_sel_r) way_word_mem[{w_pick, word}] <= data_r;
      else line_word_mem[{l_pick, word}] <= data_r;
    end
    if (cmd.acc) begin
      line_word_q <= line_word_mem[{l_pick, word}];
      way_word_q  <= way_word_mem[{w_pick, word}];
    end
  end

  assign out_word = {2'b00, misses_r, hits_r, bad_out_r, hit_out_r, dest_out_r, rd_r};

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n) lfsr_r != 16'h0)
    else $error("victim LFSR locked at zero");
  a_fill_miss: assert property (@(posedge clk) disable iff (!rst_n) cmd.fill |-> !hit_r)
    else $error("fill on a hit");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.fin |=> $stable(hits_r) && $stable(misses_r))
    else $error("counter moved outside result");
endmodule
`default_nettype wire
